/* src/tkft_pkg.sv */
package tkft_pkg;

  localparam int unsigned TickW   = 32;
  localparam int unsigned HandleW = 16;
  localparam int unsigned OpW     = 3;
  localparam int unsigned StatW   = 2;
  localparam int unsigned EntryW  = TickW + HandleW;

  typedef enum logic [OpW-1:0] {
    OP_APPEND = 3'd0,
    OP_LOOKUP = 3'd1,
    OP_DELETE = 3'd2,
    OP_COUNT  = 3'd3,
    OP_POP    = 3'd4
  } tkft_op_e;

  typedef enum logic [StatW-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BAD_TICK = 2'd2
  } tkft_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FIN
  } tkft_state_e;

  // Result of one operation, apart from the entry count.
  typedef struct packed {
    logic               found;
    logic [HandleW-1:0] result_handle;
    tkft_status_e       status;
  } tkft_res_t;

endpackage

/* src/tkft_if.sv */
interface tkft_in_if;
  logic                              valid;
  logic                              ready;
  logic [tkft_pkg::OpW-1:0]          opcode;
  logic signed [tkft_pkg::TickW-1:0] tick;
  logic [tkft_pkg::HandleW-1:0]      frame_handle;
  logic                              exact_match;

  modport source (output valid, opcode, tick, frame_handle, exact_match, input ready);
  modport sink   (input valid, opcode, tick, frame_handle, exact_match, output ready);
endinterface

interface tkft_out_if #(
  parameter int unsigned CntW = 5
);
  logic                           valid;
  logic                           ready;
  logic                           found;
  logic [tkft_pkg::HandleW-1:0]   result_handle;
  logic [CntW-1:0]                entry_count;
  logic [tkft_pkg::StatW-1:0]     status;

  modport source (output valid, found, result_handle, entry_count, status, input ready);
  modport sink   (input valid, found, result_handle, entry_count, status, output ready);
endinterface

/* src/tick_keyed_frame_table_core.sv */
// Tick-keyed frame table: an ordered ring of up to DEPTH (tick, handle) entries in insertion
// order. Every input word (append, lookup, delete older than tick, count, pop oldest) yields
// exactly one output word. The input side takes one word at a time and is not ready while an
// operation runs. Append, count, pop, unknown opcodes, and lookup or delete on an empty table
// or with a negative tick skip the walk and go from accept straight to a registered result.
// Lookup and delete walk the ring one entry per cycle through the entry RAM's single read
// port and one shared signed compare; lookup stops at the first entry at or above the tick.
// A finished result sits in an output register, so the next word is accepted while it waits
// to be taken. Delete visits all entries, keeping survivors in order from the current head.
module tick_keyed_frame_table_core #(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned IdxW = $clog2(DEPTH),
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tkft_in_if.sink     in_i,
  tkft_out_if.source  out_o
);

  logic                         ram_we;
  logic [IdxW-1:0]              ram_waddr;
  logic [tkft_pkg::EntryW-1:0]  ram_wdata;
  logic [IdxW-1:0]              ram_raddr;
  logic [tkft_pkg::EntryW-1:0]  ram_rdata;

  logic                         res_valid;
  logic                         res_ready;
  tkft_pkg::tkft_res_t          res;
  logic [CntW-1:0]              count;

  logic                         out_valid_q;
  tkft_pkg::tkft_res_t          out_res_q;
  logic [CntW-1:0]              out_count_q;

  // Entry store: tick in the upper bits, handle in the lower bits.
  tkft_ram #(
    .Width (tkft_pkg::EntryW),
    .Depth (DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sequencer: holds head and count, runs the walk and builds the result.
  tkft_seq #(
    .DEPTH (DEPTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .opcode_i    (in_i.opcode),
    .tick_i      (in_i.tick),
    .handle_i    (in_i.frame_handle),
    .exact_i     (in_i.exact_match),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .count_o     (count),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  // Output register: load a finished result when the slot is empty or being drained.
  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  // Hold the payload until the word is taken.
  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_res_q   <= res;
      out_count_q <= count;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.found         = out_res_q.found;
  assign out_o.result_handle = out_res_q.result_handle;
  assign out_o.entry_count   = out_count_q;
  assign out_o.status        = out_res_q.status;

endmodule

/* src/tkft_ram.sv */
module tkft_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* src/tkft_seq.sv */
module tkft_seq #(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned IdxW = $clog2(DEPTH),
  localparam int unsigned CntW = $clog2(DEPTH + 1),
  localparam int unsigned SumW = IdxW + 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tkft_pkg::OpW-1:0]      opcode_i,
  input  logic [tkft_pkg::TickW-1:0]    tick_i,
  input  logic [tkft_pkg::HandleW-1:0]  handle_i,
  input  logic                          exact_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output tkft_pkg::tkft_res_t           res_o,
  output logic [CntW-1:0]               count_o,
  output logic                          ram_we_o,
  output logic [IdxW-1:0]               ram_waddr_o,
  output logic [tkft_pkg::EntryW-1:0]   ram_wdata_o,
  output logic [IdxW-1:0]               ram_raddr_o,
  input  logic [tkft_pkg::EntryW-1:0]   ram_rdata_i
);

  tkft_pkg::tkft_state_e state_q, state_d;
  tkft_pkg::tkft_op_e    op_q, op_d;
  logic [tkft_pkg::TickW-1:0]   tick_q, tick_d;
  logic                         exact_q, exact_d;
  logic [IdxW-1:0]              head_q, head_d;
  logic [CntW-1:0]              count_q, count_d;
  logic [IdxW-1:0]              rd_ptr_q, rd_ptr_d;
  logic [IdxW-1:0]              wr_ptr_q, wr_ptr_d;
  logic [CntW-1:0]              ev_q, ev_d;
  logic [CntW-1:0]              kept_q, kept_d;
  logic [tkft_pkg::HandleW-1:0] prev_h_q, prev_h_d;
  tkft_pkg::tkft_res_t          res_q, res_d;

  logic [tkft_pkg::TickW-1:0]   ent_tick;
  logic [tkft_pkg::HandleW-1:0] ent_h;
  logic                         ent_ge, ent_eq, ent_last, walk_stop, walk_start;
  logic [SumW-1:0]              tail_sum;
  logic [IdxW-1:0]              tail_idx;

  function automatic logic [IdxW-1:0] ring_inc(input logic [IdxW-1:0] p);
    ring_inc = (p == IdxW'(DEPTH - 1)) ? '0 : p + IdxW'(1);
  endfunction

  // One shared compare unit examines the entry read in the previous cycle.
  assign ent_tick  = ram_rdata_i[tkft_pkg::EntryW-1:tkft_pkg::HandleW];
  assign ent_h     = ram_rdata_i[tkft_pkg::HandleW-1:0];
  assign ent_ge    = $signed(ent_tick) >= $signed(tick_q);
  assign ent_eq    = ent_tick == tick_q;
  assign ent_last  = ev_q == (count_q - CntW'(1));
  assign walk_stop = (op_q == tkft_pkg::OP_LOOKUP) ? (ent_ge || ent_last) : ent_last;

  assign walk_start = ((opcode_i == tkft_pkg::OP_LOOKUP) || (opcode_i == tkft_pkg::OP_DELETE))
                      && (count_q != '0) && !tick_i[tkft_pkg::TickW-1];

  assign tail_sum = SumW'(head_q) + SumW'(count_q);
  assign tail_idx = (tail_sum >= SumW'(DEPTH)) ? IdxW'(tail_sum - SumW'(DEPTH))
                                               : tail_sum[IdxW-1:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tkft_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = walk_start ? tkft_pkg::S_WALK : tkft_pkg::S_FIN;
        end
      end
      tkft_pkg::S_WALK: begin
        if (walk_stop) begin
          state_d = tkft_pkg::S_FIN;
        end
      end
      tkft_pkg::S_FIN: begin
        if (res_ready_i) begin
          state_d = tkft_pkg::S_IDLE;
        end
      end
      default: state_d = tkft_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    op_d        = op_q;
    tick_d      = tick_q;
    exact_d     = exact_q;
    head_d      = head_q;
    count_d     = count_q;
    rd_ptr_d    = rd_ptr_q;
    wr_ptr_d    = wr_ptr_q;
    ev_d        = ev_q;
    kept_d      = kept_q;
    prev_h_d    = prev_h_q;
    res_d       = res_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = wr_ptr_q;
    ram_wdata_o = {ent_tick, ent_h};
    ram_raddr_o = rd_ptr_q;
    in_ready_o  = state_q == tkft_pkg::S_IDLE;
    res_valid_o = state_q == tkft_pkg::S_FIN;

    unique case (state_q)
      tkft_pkg::S_IDLE: begin
        if (in_valid_i) begin
          op_d        = tkft_pkg::tkft_op_e'(opcode_i);
          tick_d      = tick_i;
          exact_d     = exact_i;
          res_d       = '{found: 1'b0, result_handle: '0, status: tkft_pkg::ST_OK};
          // Start the walk at the oldest entry.
          ram_raddr_o = head_q;
          rd_ptr_d    = ring_inc(head_q);
          wr_ptr_d    = head_q;
          ev_d        = '0;
          kept_d      = '0;
          prev_h_d    = '0;
          unique case (opcode_i)
            tkft_pkg::OP_APPEND: begin
              if (tick_i[tkft_pkg::TickW-1] || (tick_i == '0)) begin
                res_d.status = tkft_pkg::ST_BAD_TICK;
              end else if (count_q == CntW'(DEPTH)) begin
                res_d.status = tkft_pkg::ST_FULL;
              end else begin
                ram_we_o    = 1'b1;
                ram_waddr_o = tail_idx;
                ram_wdata_o = {tick_i, handle_i};
                count_d     = count_q + CntW'(1);
              end
            end
            tkft_pkg::OP_DELETE: begin
              if (tick_i[tkft_pkg::TickW-1]) begin
                count_d = '0;
              end
            end
            tkft_pkg::OP_POP: begin
              if (count_q != '0) begin
                head_d  = ring_inc(head_q);
                count_d = count_q - CntW'(1);
              end
            end
            tkft_pkg::OP_LOOKUP, tkft_pkg::OP_COUNT: ;
            default: ;
          endcase
        end
      end
      tkft_pkg::S_WALK: begin
        rd_ptr_d = ring_inc(rd_ptr_q);
        ev_d     = ev_q + CntW'(1);
        prev_h_d = ent_h;
        if (op_q == tkft_pkg::OP_LOOKUP) begin
          if (ent_ge) begin
            if (ent_eq) begin
              res_d.found         = 1'b1;
              res_d.result_handle = ent_h;
            end else if (!exact_q) begin
              res_d.found         = 1'b1;
              res_d.result_handle = (ev_q == '0) ? ent_h : prev_h_q;
            end
          end else if (ent_last && !exact_q) begin
            res_d.found         = 1'b1;
            res_d.result_handle = ent_h;
          end
        end else begin
          // Compact kept entries toward the head; writes trail the reads.
          if (ent_ge) begin
            ram_we_o = 1'b1;
            wr_ptr_d = ring_inc(wr_ptr_q);
            kept_d   = kept_q + CntW'(1);
          end
          if (ent_last) begin
            count_d = ent_ge ? kept_q + CntW'(1) : kept_q;
          end
        end
      end
      tkft_pkg::S_FIN: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tkft_pkg::S_IDLE;
      head_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    tick_q   <= tick_d;
    exact_q  <= exact_d;
    rd_ptr_q <= rd_ptr_d;
    wr_ptr_q <= wr_ptr_d;
    ev_q     <= ev_d;
    kept_q   <= kept_d;
    prev_h_q <= prev_h_d;
    res_q    <= res_d;
  end

  assign res_o   = res_q;
  assign count_o = count_q;

endmodule

/* sim/tb_tick_keyed_frame_table_core.sv */
`timescale 1ns / 100ps

module tb_tick_keyed_frame_table_core;

  localparam int unsigned Depth         = 16;
  localparam int unsigned CntW          = $clog2(Depth + 1);
  localparam int unsigned RandomWords   = 700;
  localparam int unsigned LongHoldOff   = 400;
  localparam int unsigned TimeoutCycles = 300_000;

  // Opcodes 5..7 are unused; the block must answer them with the count only.
  localparam logic [tkft_pkg::OpW-1:0] OP_RSVD5 = 3'd5;
  localparam logic [tkft_pkg::OpW-1:0] OP_RSVD7 = 3'd7;

  // One input word as the sender drives it.
  typedef struct packed {
    logic [tkft_pkg::OpW-1:0]          op;
    logic signed [tkft_pkg::TickW-1:0] tick;
    logic [tkft_pkg::HandleW-1:0]      handle;
    logic                              exact;
  } table_cmd_t;

  // One output word as the receiver should see it.
  typedef struct packed {
    logic                         found;
    logic [tkft_pkg::HandleW-1:0] handle;
    logic [CntW-1:0]              count;
    tkft_pkg::tkft_status_e       status;
  } table_reply_t;

  typedef struct packed {
    logic signed [tkft_pkg::TickW-1:0] tick;
    logic [tkft_pkg::HandleW-1:0]      handle;
  } frame_entry_t;

  // One row of the directed table: the word, how many times to send it, and
  // an optional hand-written reply that replaces the predicted one.
  typedef struct {
    table_cmd_t   cmd;
    int unsigned  reps;
    bit           typed;
    table_reply_t reply;
  } stim_row_t;

  logic clk;
  logic rst_n;

  tkft_in_if                  in_if ();
  tkft_out_if #(.CntW(CntW))  out_if ();

  tick_keyed_frame_table_core #(
    .DEPTH(Depth)
  ) DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Shadow of the table, oldest entry at index 0. Ring placement inside the
  // block is invisible from outside, so a plain queue is enough.
  frame_entry_t       shadow_entries_q[$];
  // Replies owed by the block, oldest first.
  table_reply_t       expected_replies_q[$];
  stim_row_t          dir_rows[$];

  logic signed [tkft_pkg::TickW-1:0] next_tick;
  int unsigned                       burst_left;
  int unsigned                       mismatch_cnt;
  int unsigned                       cycle_cnt;
  bit                                hold_off_req;

  // Clock: 8 ns period.
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Apply one word to the shadow table and return the reply it must cause.
  function automatic table_reply_t apply_table_op(input table_cmd_t c);
    table_reply_t r;
    frame_entry_t kept[$];
    bit           hit;
    r = '{found: 1'b0, handle: '0, count: '0, status: tkft_pkg::ST_OK};
    hit = 1'b0;
    case (c.op)
      tkft_pkg::OP_APPEND: begin
        // Bad tick wins over full table.
        if ($signed(c.tick) <= 0) begin
          r.status = tkft_pkg::ST_BAD_TICK;
        end else if (shadow_entries_q.size() >= Depth) begin
          r.status = tkft_pkg::ST_FULL;
        end else begin
          shadow_entries_q.push_back('{tick: c.tick, handle: c.handle});
        end
      end
      tkft_pkg::OP_LOOKUP: begin
        // Negative query or empty table: nothing found.
        if ($signed(c.tick) >= 0 && shadow_entries_q.size() > 0) begin
          foreach (shadow_entries_q[k]) begin
            if (!hit && $signed(shadow_entries_q[k].tick) >= $signed(c.tick)) begin
              hit = 1'b1;
              if (shadow_entries_q[k].tick == c.tick) begin
                r.found  = 1'b1;
                r.handle = shadow_entries_q[k].handle;
              end else if (!c.exact) begin
                // Step back one entry, or stay on the oldest.
                r.found  = 1'b1;
                r.handle = shadow_entries_q[(k == 0) ? 0 : k - 1].handle;
              end
            end
          end
          // Query above every tick: newest entry unless exact.
          if (!hit && !c.exact) begin
            r.found  = 1'b1;
            r.handle = shadow_entries_q[$].handle;
          end
        end
      end
      tkft_pkg::OP_DELETE: begin
        // Negative bound drops everything; else keep ticks at or above it.
        foreach (shadow_entries_q[k]) begin
          if ($signed(c.tick) >= 0 && $signed(shadow_entries_q[k].tick) >= $signed(c.tick)) begin
            kept.push_back(shadow_entries_q[k]);
          end
        end
        shadow_entries_q = kept;
      end
      tkft_pkg::OP_POP: begin
        if (shadow_entries_q.size() > 0) begin
          void'(shadow_entries_q.pop_front());
        end
      end
      default: ;
    endcase
    r.count = CntW'(shadow_entries_q.size());
    return r;
  endfunction

  function automatic void row_pred(input logic [tkft_pkg::OpW-1:0] op,
                                   input logic signed [tkft_pkg::TickW-1:0] tick,
                                   input logic [tkft_pkg::HandleW-1:0] handle, input logic exact,
                                   input int unsigned reps);
    stim_row_t row;
    row.cmd   = '{op: op, tick: tick, handle: handle, exact: exact};
    row.reps  = reps;
    row.typed = 1'b0;
    row.reply = '0;
    dir_rows.push_back(row);
  endfunction

  function automatic void row_typed(input logic [tkft_pkg::OpW-1:0] op,
                                    input logic signed [tkft_pkg::TickW-1:0] tick,
                                    input logic [tkft_pkg::HandleW-1:0] handle, input logic exact,
                                    input logic found, input logic [tkft_pkg::HandleW-1:0] rhandle,
                                    input int unsigned count,
                                    input tkft_pkg::tkft_status_e status);
    stim_row_t row;
    row.cmd   = '{op: op, tick: tick, handle: handle, exact: exact};
    row.reps  = 1;
    row.typed = 1'b1;
    row.reply = '{found: found, handle: rhandle, count: CntW'(count), status: status};
    dir_rows.push_back(row);
  endfunction

  // Build one random word. Most words are what a player of recorded frames
  // would send: rising ticks, lookups and deletes near stored ticks. The
  // rest is noise: full-range ticks, negative bounds, unused opcodes.
  function automatic table_cmd_t gen_table_cmd();
    table_cmd_t                        c;
    int unsigned                       pick;
    logic signed [tkft_pkg::TickW-1:0] near;
    pick     = $urandom_range(0, 99);
    c.op     = tkft_pkg::OP_COUNT;
    c.tick   = $urandom();
    c.handle = tkft_pkg::HandleW'($urandom());
    c.exact  = 1'($urandom_range(0, 1));
    near     = (shadow_entries_q.size() > 0)
             ? shadow_entries_q[$urandom_range(0, shadow_entries_q.size() - 1)].tick
             : next_tick;
    if (pick < 40) begin
      c.op = tkft_pkg::OP_APPEND;
      if ($urandom_range(0, 9) < 8) begin
        c.tick    = next_tick;
        next_tick = next_tick + $urandom_range(0, 3);
        // Jump now and then so the upper tick bits move too.
        if ($urandom_range(0, 49) == 0) begin
          next_tick = $urandom_range(1, 32'h7FFF_0000);
        end
        if (next_tick > 32'sh7FFF_FF00 || next_tick <= 0) begin
          next_tick = 1;
        end
      end
    end else if (pick < 65) begin
      c.op = tkft_pkg::OP_LOOKUP;
      case ($urandom_range(0, 5))
        0, 1: c.tick = near;
        2:    c.tick = near + 1;
        3:    c.tick = near - 1;
        4:    c.tick = next_tick + $urandom_range(0, 2);
        default: ;
      endcase
    end else if (pick < 75) begin
      c.op = tkft_pkg::OP_DELETE;
      case ($urandom_range(0, 9))
        0:       c.tick = {1'b1, 31'($urandom())};
        7, 8:    c.tick = near + 1;
        9:       ;
        default: c.tick = near;
      endcase
    end else if (pick < 85) begin
      c.op = tkft_pkg::OP_POP;
    end else if (pick >= 93) begin
      c.op = tkft_pkg::OpW'($urandom_range(OP_RSVD5, OP_RSVD7));
    end
    return c;
  endfunction

  // Offer one word in bursts: pause between bursts, then hold valid until the
  // block takes the word. Called just after a rising edge.
  task automatic send_word(input table_cmd_t c, input bit typed, input table_reply_t reply);
    table_reply_t predicted;
    @(negedge clk);
    if (burst_left == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_if.valid        <= 1'b1;
    in_if.opcode       <= c.op;
    in_if.tick         <= c.tick;
    in_if.frame_handle <= c.handle;
    in_if.exact_match  <= c.exact;
    do @(posedge clk); while (!in_if.ready);
    // Word taken at this edge: advance the shadow table.
    predicted = apply_table_op(c);
    expected_replies_q.push_back(typed ? reply : predicted);
  endtask

  // Stimulus: reset, directed table, random words, then drain.
  initial begin : stimulus
    table_cmd_t c;
    in_if.valid        = 1'b0;
    in_if.opcode       = tkft_pkg::OP_COUNT;
    in_if.tick         = '0;
    in_if.frame_handle = '0;
    in_if.exact_match  = 1'b0;
    hold_off_req       = 1'b0;
    mismatch_cnt       = 0;
    burst_left         = 0;
    next_tick          = 1000;
    rst_n              = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    // Empty table: every operation is harmless and reports a count of zero.
    row_typed(tkft_pkg::OP_COUNT,  0,  16'h0000, 1'b0, 1'b0, 16'h0000, 0, tkft_pkg::ST_OK);
    row_typed(tkft_pkg::OP_LOOKUP, 5,  16'h0000, 1'b0, 1'b0, 16'h0000, 0, tkft_pkg::ST_OK);
    row_typed(tkft_pkg::OP_POP,    0,  16'h0000, 1'b0, 1'b0, 16'h0000, 0, tkft_pkg::ST_OK);
    row_typed(tkft_pkg::OP_DELETE, 10, 16'h0000, 1'b0, 1'b0, 16'h0000, 0, tkft_pkg::ST_OK);
    // Zero and most negative tick are refused.
    row_typed(tkft_pkg::OP_APPEND, 0,  16'h1234, 1'b0, 1'b0, 16'h0000, 0,
              tkft_pkg::ST_BAD_TICK);
    row_typed(tkft_pkg::OP_APPEND, 32'h8000_0000, 16'hFFFF, 1'b1, 1'b0, 16'h0000, 0,
              tkft_pkg::ST_BAD_TICK);
    row_typed(tkft_pkg::OP_APPEND, 1,  16'h0000, 1'b0, 1'b0, 16'h0000, 1, tkft_pkg::ST_OK);
    row_typed(tkft_pkg::OP_APPEND, 10, 16'hAAAA, 1'b0, 1'b0, 16'h0000, 2, tkft_pkg::ST_OK);
    row_typed(tkft_pkg::OP_APPEND, 20, 16'h5555, 1'b1, 1'b0, 16'h0000, 3, tkft_pkg::ST_OK);
    // Query above every tick: exact misses, nearest gives the newest.
    row_typed(tkft_pkg::OP_LOOKUP, 100, 16'h0000, 1'b1, 1'b0, 16'h0000, 3, tkft_pkg::ST_OK);
    row_typed(tkft_pkg::OP_LOOKUP, 100, 16'h0000, 1'b0, 1'b1, 16'h5555, 3, tkft_pkg::ST_OK);
    row_typed(tkft_pkg::OP_APPEND, 32'h7FFF_FFFF, 16'hFFFF, 1'b0, 1'b0, 16'h0000, 4,
              tkft_pkg::ST_OK);
    row_typed(tkft_pkg::OP_LOOKUP, 10, 16'h0000, 1'b1, 1'b1, 16'hAAAA, 4, tkft_pkg::ST_OK);
    row_typed(tkft_pkg::OP_LOOKUP, 15, 16'h0000, 1'b1, 1'b0, 16'h0000, 4, tkft_pkg::ST_OK);
    row_typed(tkft_pkg::OP_LOOKUP, 15, 16'h0000, 1'b0, 1'b1, 16'hAAAA, 4, tkft_pkg::ST_OK);
    // Query below the first tick falls on the oldest entry.
    row_typed(tkft_pkg::OP_LOOKUP, 0,  16'h0000, 1'b0, 1'b1, 16'h0000, 4, tkft_pkg::ST_OK);
    // Negative query finds nothing.
    row_typed(tkft_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 16'h0000, 1'b0, 1'b0, 16'h0000, 4,
              tkft_pkg::ST_OK);
    row_typed(tkft_pkg::OP_LOOKUP, 32'h7FFF_FFFF, 16'h0000, 1'b1, 1'b1, 16'hFFFF, 4,
              tkft_pkg::ST_OK);
    row_typed(tkft_pkg::OP_POP,    0,  16'h0000, 1'b0, 1'b0, 16'h0000, 3, tkft_pkg::ST_OK);
    row_typed(tkft_pkg::OP_DELETE, 20, 16'h0000, 1'b0, 1'b0, 16'h0000, 2, tkft_pkg::ST_OK);
    // Unused opcodes only report the count.
    row_typed(OP_RSVD5, 32'h1234_5678, 16'hBEEF, 1'b0, 1'b0, 16'h0000, 2, tkft_pkg::ST_OK);
    row_typed(OP_RSVD7, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b0, 16'h0000, 2, tkft_pkg::ST_OK);
    // Fill to the top, then overflow; bad tick is still reported first.
    row_pred (tkft_pkg::OP_APPEND, 30, 16'h1234, 1'b0, 14);
    row_typed(tkft_pkg::OP_APPEND, 40, 16'h4321, 1'b0, 1'b0, 16'h0000, 16, tkft_pkg::ST_FULL);
    row_typed(tkft_pkg::OP_APPEND, 0,  16'h4321, 1'b0, 1'b0, 16'h0000, 16,
              tkft_pkg::ST_BAD_TICK);
    // Pop and refill so the ring wraps, then look across the seam.
    row_pred (tkft_pkg::OP_POP,    0,  16'h0000, 1'b0, 3);
    row_pred (tkft_pkg::OP_APPEND, 50, 16'h7777, 1'b0, 2);
    row_pred (tkft_pkg::OP_LOOKUP, 45, 16'h0000, 1'b0, 1);
    // Negative bound wipes the table.
    row_typed(tkft_pkg::OP_DELETE, 32'h8000_0000, 16'h0000, 1'b0, 1'b0, 16'h0000, 0,
              tkft_pkg::ST_OK);

    foreach (dir_rows[i]) begin
      repeat (dir_rows[i].reps) begin
        send_word(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].reply);
      end
    end

    // Ask the receiver for its long hold-off while words keep coming.
    hold_off_req = 1'b1;
    repeat (RandomWords) begin
      c = gen_table_cmd();
      send_word(c, 1'b0, '0);
    end
    @(negedge clk);
    in_if.valid <= 1'b0;

    // Drain, then idle past the longest walk to catch stray words.
    while (expected_replies_q.size() != 0) @(posedge clk);
    repeat (4 * (Depth + 2)) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("tick_keyed_frame_table_core verification clean");
    end else begin
      $display("tick_keyed_frame_table_core verification failed");
    end
    $finish;
  end

  // Receiver: switch between stall patterns after spans of random length, and once
  // hold ready low long enough for the block to back up into its input.
  initial begin : receiver
    int unsigned mode;
    int unsigned span;
    int unsigned hold_left;
    int unsigned rx_cyc;
    bit          hold_taken;
    out_if.ready = 1'b0;
    hold_left    = 0;
    rx_cyc       = 0;
    hold_taken   = 1'b0;
    @(posedge rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 80);
      repeat (span) begin
        @(negedge clk);
        rx_cyc++;
        if (hold_off_req && !hold_taken) begin
          hold_taken = 1'b1;
          hold_left  = LongHoldOff;
        end
        if (hold_left > 0) begin
          hold_left--;
          out_if.ready <= 1'b0;
        end else begin
          case (mode)
            0:       out_if.ready <= 1'b1;
            1:       out_if.ready <= 1'($urandom_range(0, 1));
            2:       out_if.ready <= (rx_cyc % 3 == 0);
            default: out_if.ready <= ($urandom_range(0, 4) != 0);
          endcase
        end
      end
    end
  end

  // Check each taken result word against the oldest owed reply.
  always @(posedge clk) begin : reply_check
    table_reply_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_replies_q.size() == 0) begin
        $error("unexpected result word: found %0d handle %0h count %0d status %0d",
               out_if.found, out_if.result_handle, out_if.entry_count, out_if.status);
        mismatch_cnt++;
      end else begin
        want = expected_replies_q.pop_front();
        if (out_if.found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, out_if.found);
          mismatch_cnt++;
        end
        if (out_if.result_handle !== want.handle) begin
          $error("result_handle: expected %0h, got %0h", want.handle, out_if.result_handle);
          mismatch_cnt++;
        end
        if (out_if.entry_count !== want.count) begin
          $error("entry_count: expected %0d, got %0d", want.count, out_if.entry_count);
          mismatch_cnt++;
        end
        if (out_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_if.status);
          mismatch_cnt++;
        end
      end
    end
  end

  // Watchdog: stop a hung run.
  initial cycle_cnt = 0;
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= TimeoutCycles) begin
      $display("tick_keyed_frame_table_core verification failed");
      $finish;
    end
  end

endmodule

/* tick_keyed_frame_table_core.f */
src/tkft_pkg.sv
src/tkft_if.sv
src/tkft_ram.sv
src/tkft_seq.sv
src/tick_keyed_frame_table_core.sv
sim/tb_tick_keyed_frame_table_core.sv
